### sv/fea_pkg.sv
package fea_pkg;

   // At most two floating-point operations per pipeline stage.
   localparam int NUM_STAGES = 21;
   localparam int STAGE_W    = $clog2(NUM_STAGES);

   localparam logic [31:0] F_HI    = 32'h42B0C0A5;
   localparam logic [31:0] F_LO    = 32'hC2B0C0A5;
   localparam logic [31:0] F_LOG2E = 32'h3FB8AA3B;
   localparam logic [31:0] F_HALF  = 32'h3F000000;
   localparam logic [31:0] F_ONE   = 32'h3F800000;
   localparam logic [31:0] F_C1    = 32'h3F318000;
   localparam logic [31:0] F_C2    = 32'hB95E8083;
   localparam logic [31:0] F_P0    = 32'h39506967;
   localparam logic [31:0] F_P1    = 32'h3AB743CE;
   localparam logic [31:0] F_P2    = 32'h3C088908;
   localparam logic [31:0] F_P3    = 32'h3D2AA9C1;
   localparam logic [31:0] F_P4    = 32'h3E2AAAAA;
   localparam logic [31:0] F_P5    = 32'h3F000000;
   localparam logic [31:0] F_QNAN  = 32'h7FC00000;

   typedef struct packed {
      logic [31:0]        x;
      logic [31:0]        fx;
      logic [31:0]        y;
      logic [31:0]        z;
      logic [31:0]        t;
      logic signed [9:0]  n;
   } pipe_type;

   function automatic logic is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   endfunction

   // Position of the most significant set bit of a 51-bit word.
   function automatic logic [5:0] msb_pos(input logic [50:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int k = 0; k < 51; k++) begin
         if (v[k]) p = 6'(k);
      end
      return p;
   endfunction

   // Rounds to nearest-even and packs; sig has its leading one at bit 49.
   function automatic logic [31:0] fp_pack(input logic s, input logic signed [11:0] ex,
                                           input logic [49:0] sig);
      logic [49:0] sg;
      logic [49:0] sh_sig;
      logic [11:0] sh;
      logic [7:0]  field;
      logic        rnd;
      logic [30:0] r;
      sg = sig;
      field = 8'd0;
      if (ex >= 12'sd255) begin
         return {s, 8'hFF, 23'd0};
      end
      if (ex <= 12'sd0) begin
         sh = 12'(12'sd1 - ex);
         if (sh > 12'd50) begin
            sg = {49'd0, |sig};
         end else begin
            sh_sig = sig >> sh;
            sg = sh_sig | {49'd0, ((sh_sig << sh) != sig)};
         end
      end else begin
         field = ex[7:0];
      end
      rnd = sg[25] & ((|sg[24:0]) | sg[26]);
      r = {field, sg[48:26]} + {30'd0, rnd};
      return {s, r};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic              s;
      logic [7:0]        ea, eb;
      logic [23:0]       ma, mb;
      logic [47:0]       p;
      logic [50:0]       w;
      logic [5:0]        pos;
      logic signed [11:0] ex;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return F_QNAN;
      if (is_inf(a) || is_inf(b)) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return F_QNAN;
         return {s, 8'hFF, 23'd0};
      end
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      p = ma * mb;
      w = {1'b0, p, 2'b00};
      pos = msb_pos(w);
      w = w << (6'd49 - pos);
      ex = 12'(signed'({4'd0, ea}) + signed'({4'd0, eb}) - 12'sd126
                - signed'({6'd0, 6'd49 - pos}));
      return fp_pack(s, ex, w[49:0]);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a_in, input logic [31:0] b_in);
      logic [31:0]        a, b;
      logic [7:0]         ea, eb;
      logic [23:0]        ma, mb;
      logic [49:0]        al, bx, bl;
      logic [7:0]         d;
      logic [50:0]        sum;
      logic [5:0]         pos;
      logic [49:0]        sig;
      logic signed [11:0] ex;
      if (is_nan(a_in) || is_nan(b_in)) return F_QNAN;
      if (is_inf(a_in) && is_inf(b_in)) begin
         return (a_in[31] != b_in[31]) ? F_QNAN : a_in;
      end
      if (is_inf(a_in)) return a_in;
      if (is_inf(b_in)) return b_in;
      if (a_in[30:0] < b_in[30:0]) begin
         a = b_in;
         b = a_in;
      end else begin
         a = a_in;
         b = b_in;
      end
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      d = ea - eb;
      al = {ma, 26'd0};
      bx = {mb, 26'd0};
      if (d >= 8'd50) begin
         bl = {49'd0, |mb};
      end else begin
         bl = bx >> d;
         bl = bl | {49'd0, ((bl << d) != bx)};
      end
      if (a[31] == b[31]) sum = {1'b0, al} + {1'b0, bl};
      else                sum = {1'b0, al} - {1'b0, bl};
      if (sum == 51'd0) return {(a[31] == b[31]) ? a[31] : 1'b0, 31'd0};
      pos = msb_pos(sum);
      if (pos == 6'd50) begin
         sig = {sum[50:2], |sum[1:0]};
         ex = 12'(signed'({4'd0, ea}) + 12'sd1);
      end else begin
         sig = sum[49:0] << (6'd49 - pos);
         ex = 12'(signed'({4'd0, ea}) - signed'({6'd0, 6'd49 - pos}));
      end
      return fp_pack(a[31], ex, sig);
   endfunction

   // a < b in IEEE order; false when either side is NaN.
   function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
      if (a[31] != b[31]) return a[31];
      if (!a[31]) return a[30:0] < b[30:0];
      return a[30:0] > b[30:0];
   endfunction

   // floor() of a value known to lie well inside the 9-bit range.
   function automatic logic signed [9:0] fp_floor(input logic [31:0] f);
      logic [23:0] sig;
      logic [23:0] q;
      logic [7:0]  sh;
      logic [9:0]  mag;
      logic        frac;
      if (f[30:23] < 8'd127) begin
         mag = 10'd0;
         frac = (f[30:0] != 31'd0);
      end else begin
         sig = {1'b1, f[22:0]};
         sh = (f[30:23] > 8'd150) ? 8'd0 : 8'd150 - f[30:23];
         q = sig >> sh;
         mag = q[9:0];
         frac = ((q << sh) != sig);
      end
      if (f[31]) return signed'(10'd0 - mag - {9'd0, frac});
      return signed'(mag);
   endfunction

   function automatic logic [31:0] int_to_fp(input logic signed [9:0] n);
      logic [9:0] mag;
      logic [3:0] p;
      logic [9:0] nm;
      mag = n[9] ? 10'(-n) : 10'(n);
      if (mag == 10'd0) return 32'd0;
      p = 4'd0;
      for (int k = 0; k < 10; k++) begin
         if (mag[k]) p = 4'(k);
      end
      nm = mag << (4'd9 - p);
      return {n[9], 8'(8'd127 + {4'd0, p}), nm[8:0], 14'd0};
   endfunction

   function automatic pipe_type stage_op(input logic [STAGE_W-1:0] idx, input pipe_type s);
      pipe_type   o;
      logic [9:0] eb;
      o = s;
      eb = 10'(s.n + 10'sd127);
      case (idx)
         5'd0: begin
            o.x = fp_lt(s.x, F_HI) ? s.x : F_HI;
            o.x = fp_lt(F_LO, o.x) ? o.x : F_LO;
         end
         5'd1: o.fx = fp_mul(s.x, F_LOG2E);
         5'd2: o.fx = fp_add(s.fx, F_HALF);
         5'd3: begin
            o.n  = fp_floor(s.fx);
            o.fx = int_to_fp(o.n);
         end
         5'd4: begin
            o.t = fp_mul(s.fx, F_C1);
            o.z = fp_mul(s.fx, F_C2);
         end
         5'd5: o.x = fp_add(s.x, {~s.t[31], s.t[30:0]});
         5'd6: o.x = fp_add(s.x, {~s.z[31], s.z[30:0]});
         5'd7: begin
            o.z = fp_mul(s.x, s.x);
            o.y = fp_mul(F_P0, s.x);
         end
         5'd8:  o.y = fp_add(s.y, F_P1);
         5'd9:  o.y = fp_mul(s.y, s.x);
         5'd10: o.y = fp_add(s.y, F_P2);
         5'd11: o.y = fp_mul(s.y, s.x);
         5'd12: o.y = fp_add(s.y, F_P3);
         5'd13: o.y = fp_mul(s.y, s.x);
         5'd14: o.y = fp_add(s.y, F_P4);
         5'd15: o.y = fp_mul(s.y, s.x);
         5'd16: o.y = fp_add(s.y, F_P5);
         5'd17: o.y = fp_mul(s.y, s.z);
         5'd18: o.y = fp_add(s.y, s.x);
         5'd19: o.y = fp_add(s.y, F_ONE);
         5'd20: o.y = fp_mul(s.y, {1'b0, eb[7:0], 23'd0});
         default: o = s;
      endcase
      return o;
   endfunction

endpackage

### sv/float_exp_approximation_core.sv
// Single-precision e^x approximation. Each transfer on the req_ side carries one IEEE-754
// argument and produces exactly one IEEE-754 result on the rsp_ side, in order. The input is
// clamped to +/-88.3762626647949 (NaN becomes the upper bound), reduced by n*ln2 with
// n = floor(x*log2e + 0.5), run through a degree-5 polynomial and scaled by 2^n. Every
// multiply and add rounds to nearest-even in single precision, subnormals included. The
// datapath is a 21-stage pipeline with at most two floating-point operations per stage; a new
// argument is taken every cycle unless a rsp_ stall has backed up to the first stage. Each
// stage has its own valid bit and holds its item when the stage after it is full and stalled,
// so a stalled result does not stop earlier stages from filling their empty slots.
module float_exp_approximation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] x_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] exp_bits
);
   import fea_pkg::*;

   pipe_type                data_ff [NUM_STAGES];
   pipe_type                data_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]   valid_ff;
   logic [NUM_STAGES-1:0]   valid_in;
   logic [NUM_STAGES:0]     ready;
   pipe_type                head;

   // The first stage sees the raw argument; the other fields start cleared.
   always_comb begin
      head   = '0;
      head.x = req_tdata;
   end

   assign ready[NUM_STAGES] = rsp_tready;

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      localparam logic [STAGE_W-1:0] IDX = STAGE_W'(i);

      // A stage takes a new transfer when it is empty or its content moves on.
      assign ready[i] = !valid_ff[i] || ready[i+1];

      if (i == 0) begin : g_first
         assign valid_in[i] = req_tvalid;
         assign data_in[i]  = stage_op(IDX, head);
      end else begin : g_rest
         assign valid_in[i] = valid_ff[i-1];
         assign data_in[i]  = stage_op(IDX, data_ff[i-1]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ready[i]) begin
            valid_ff[i] <= valid_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[i] && valid_in[i]) begin
            data_ff[i] <= data_in[i];
         end
      end
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = data_ff[NUM_STAGES-1].y;

`ifndef SYNTHESIS
   // The approximation is positive for every argument, so no result has its sign set.
   a_rsp_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[31])
      else $error("negative or NaN-signed result");

   // After the clamp stage no NaN or infinity remains in the argument.
   a_clamp_finite: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> data_ff[0].x[30:23] != 8'hFF)
      else $error("clamp left a non-finite argument");

   // An accepted argument always lands in the first stage.
   a_first_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted transfer lost at pipeline entry");
`endif

endmodule

### test/float_exp_approximation_core_tb.sv
module float_exp_approximation_core_tb;
   import fea_pkg::*;

   localparam logic [31:0] SIGN_BIT    = 32'h80000000;
   localparam logic [31:0] F_POS_INF   = 32'h7F800000;
   localparam logic [31:0] F_NEG_INF   = 32'hFF800000;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          DRAIN_WAIT  = NUM_STAGES + 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   logic [31:0] exp_results_q[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;

   float_exp_approximation_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Single-precision arithmetic. A value is handled as an integer significand m times
   // 2^e; every operation is computed exactly (or with a sticky bit) and rounded once.
   // ---------------------------------------------------------------------------------------

   // Rounds m * 2^e to nearest-even single precision, subnormals and overflow included.
   function automatic logic [31:0] sp_round(input logic s, input longint unsigned m,
                                            input int e);
      int                biased;
      int                sh;
      longint unsigned   q;
      longint unsigned   rem;
      longint unsigned   half;
      longint unsigned   res;
      if (m == 0) return {s, 31'd0};
      while (!m[62]) begin
         m = m << 1;
         e = e - 1;
      end
      biased = e + 62 + 127;
      if (biased >= 255) return {s, 8'hFF, 23'd0};
      sh = 39 + ((biased < 1) ? (1 - biased) : 0);
      // Anything shifted this far is below half of the smallest subnormal.
      if (sh >= 64) return {s, 31'd0};
      q    = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      // For normal numbers q carries the hidden one, which lifts the exponent field by one;
      // a carry out of the significand moves into the exponent the same way.
      res = ((biased >= 1) ? (longint'(biased - 1) << 23) : 64'd0) + q;
      return {s, res[30:0]};
   endfunction

   function automatic void sp_split(input logic [31:0] a, output longint unsigned m,
                                    output int e);
      if (a[30:23] == 8'd0) begin
         m = {41'd0, a[22:0]};
         e = -149;
      end else begin
         m = {40'd0, 1'b1, a[22:0]};
         e = int'(a[30:23]) - 150;
      end
   endfunction

   function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
      logic            s;
      longint unsigned ma, mb;
      int              ea, eb;
      s = a[31] ^ b[31];
      // Only the final scaling can see an infinity, and it never meets a zero there.
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {s, 8'hFF, 23'd0};
      sp_split(a, ma, ea);
      sp_split(b, mb, eb);
      if (ma == 0 || mb == 0) return {s, 31'd0};
      return sp_round(s, ma * mb, ea + eb);
   endfunction

   function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
      longint unsigned ma, mb, big, sml, mag;
      int              ea, eb, d;
      logic            sa, sb, s;
      sp_split(a, ma, ea);
      sp_split(b, mb, eb);
      if (ma == 0 && mb == 0) return {a[31] & b[31], 31'd0};
      if (ma == 0) return b;
      if (mb == 0) return a;
      sa = a[31];
      sb = b[31];
      if (ea < eb) begin
         {ma, mb} = {mb, ma};
         {ea, eb} = {eb, ea};
         {sa, sb} = {sb, sa};
      end
      d   = ea - eb;
      big = ma << 38;
      if (d >= 62) begin
         sml = 64'd1;
      end else begin
         sml = (mb << 38) >> d;
         if ((sml << d) != (mb << 38)) sml = sml | 64'd1;
      end
      if (sa == sb) begin
         mag = big + sml;
         s   = sa;
      end else if (big >= sml) begin
         mag = big - sml;
         s   = sa;
      end else begin
         mag = sml - big;
         s   = sb;
      end
      // An exact cancellation gives +0 under round-to-nearest.
      if (mag == 0) return 32'd0;
      return sp_round(s, mag, ea - 38);
   endfunction

   // IEEE a < b; false whenever a NaN is involved, and the two zeros compare equal.
   function automatic logic sp_less(input logic [31:0] a, input logic [31:0] b);
      if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
         return 1'b0;
      if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
      if (a[31] != b[31]) return a[31];
      if (!a[31]) return a[30:0] < b[30:0];
      return a[30:0] > b[30:0];
   endfunction

   // Conversion toward zero; the argument is always well inside +/-256 here.
   function automatic int sp_trunc(input logic [31:0] f);
      int mag;
      if (f[30:23] < 8'd127) return 0;
      mag = int'({1'b1, f[22:0]} >> (150 - int'(f[30:23])));
      return f[31] ? -mag : mag;
   endfunction

   function automatic logic [31:0] exp_of(input logic [31:0] arg);
      logic [31:0] coeff[6];
      logic [31:0] x, fx, t, z, y;
      logic [31:0] pow2;
      int          n;
      coeff = '{F_P0, F_P1, F_P2, F_P3, F_P4, F_P5};
      // A NaN fails the first comparison and therefore takes the upper bound.
      x = sp_less(arg, F_HI) ? arg : F_HI;
      x = sp_less(F_LO, x) ? x : F_LO;
      fx = sp_add(sp_mul(x, F_LOG2E), F_HALF);
      // Floor from truncation: step down by one where truncation rounded up.
      n = sp_trunc(fx);
      t = sp_round(n < 0, longint'((n < 0) ? -n : n), 0);
      fx = sp_less(fx, t) ? sp_add(t, F_ONE | SIGN_BIT) : t;
      t = sp_mul(fx, F_C1);
      z = sp_mul(fx, F_C2);
      x = sp_add(x, t ^ SIGN_BIT);
      x = sp_add(x, z ^ SIGN_BIT);
      z = sp_mul(x, x);
      y = coeff[0];
      for (int i = 1; i < 6; i++) begin
         y = sp_mul(y, x);
         y = sp_add(y, coeff[i]);
      end
      y = sp_add(sp_add(sp_mul(y, z), x), F_ONE);
      // n = 128 builds +inf and n = -127 builds +0, both on purpose.
      n = sp_trunc(fx);
      pow2 = 32'(n + 127) << 23;
      return sp_mul(y, pow2);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Receiver side, checking and the run limit.
   // ---------------------------------------------------------------------------------------

   // The receiver's ready is redrawn every cycle; a requested hold-off keeps it low while
   // hold_cycles counts down, so that the pipeline backs up into req_tready.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready  <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s, got %08h, expected %08h", cycles, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_results_q.size() == 0) begin
            report_mismatch("result transfer with nothing outstanding", rsp_tdata, 32'd0);
         end else begin
            want = exp_results_q.pop_front();
            if (rsp_tdata !== want) report_mismatch("exp_bits", rsp_tdata, want);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sender side. Every task starts and ends just after a falling edge.
   // ---------------------------------------------------------------------------------------

   task automatic send_arg(input logic [31:0] arg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= arg;
      do @(posedge clock); while (!req_tready);
      exp_results_q.push_back(exp_of(arg));
      @(negedge clock);
   endtask

   // The sender stops and waits until every outstanding result has been transferred.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (exp_results_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic logic [31:0] random_arg();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(9))
         0, 1: ;                                                 // any pattern at all
         2, 3, 4, 5: r[30:23] = 8'($urandom_range(100, 133));    // the useful range
         6: r[30:8] = F_HI[30:8];                                // next to the clamps
         7: r[30:23] = 8'($urandom_range(0, 126));               // tiny magnitudes
         8: r[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;        // NaN, inf, subnormal
         default: r[30:23] = 8'($urandom_range(127, 160));       // from one up to beyond the clamps
      endcase
      return r;
   endfunction

   task automatic test_directed();
      logic [31:0] args[$];
      args = '{32'h00000000, 32'h80000000, F_POS_INF, F_NEG_INF, F_QNAN, 32'h7F800001,
               32'hFFFFFFFF, F_HI, F_LO, 32'h42B0C0A6, 32'hC2B0C0A6, 32'h7F7FFFFF,
               32'hFF7FFFFF, 32'h00000001, 32'h80000001, 32'h007FFFFF, F_ONE,
               32'hBF800000, F_HALF, 32'h3F317218, 32'h42B00000, 32'hC2AE0000,
               32'hC2AF0000, 32'h3EFFFFFF, 32'hBF000000};
      foreach (args[i]) send_arg(args[i]);
      drain_results();
   endtask

   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_arg(random_arg());
      drain_results();
   endtask

   // The receiver stalls for a long stretch while arguments keep coming, so the pipeline
   // fills completely and must hold off the sender until the stall ends.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles   = 150;
      repeat (60) send_arg(random_arg());
      drain_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random(330, 15, 69);
      test_random(330, 69, 15);
      test_random(340, 0, 0);
      test_backpressure();

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
sv/fea_pkg.sv
sv/float_exp_approximation_core.sv
test/float_exp_approximation_core_tb.sv
